@@ src/kabf_pkg.sv @@
// Shared types, constants and the operation sequence of the angle and bias filter.
package kabf_pkg;

	localparam int unsigned WORD_WIDTH_DEF = 48;
	localparam int unsigned FRAC_BITS_DEF  = 32;
	localparam int unsigned FIELD_WIDTH    = 48;
	localparam int unsigned REG_WIDTH      = 32;
	localparam int unsigned REG_FRAC       = 32;
	localparam int unsigned CFG_IDX_WIDTH  = 2;

	localparam logic [REG_WIDTH-1:0] ANGLE_NOISE_RST   = 32'd4294967;
	localparam logic [REG_WIDTH-1:0] BIAS_NOISE_RST    = 32'd12884902;
	localparam logic [REG_WIDTH-1:0] MEASURE_NOISE_RST = 32'd128849019;
	localparam logic [REG_WIDTH-1:0] STEP_TIME_RST     = 32'd42949673;

	// configuration register indexes
	localparam logic [CFG_IDX_WIDTH-1:0] REG_ANGLE_NOISE   = 2'd0;
	localparam logic [CFG_IDX_WIDTH-1:0] REG_BIAS_NOISE    = 2'd1;
	localparam logic [CFG_IDX_WIDTH-1:0] REG_MEASURE_NOISE = 2'd2;
	localparam logic [CFG_IDX_WIDTH-1:0] REG_STEP_TIME     = 2'd3;

	// datapath operand selects
	typedef enum logic [3:0] {
		SEL_ZERO, SEL_ANGLE, SEL_BIAS, SEL_P00, SEL_P01, SEL_P10, SEL_P11,
		SEL_Z, SEL_W, SEL_RATE, SEL_T, SEL_U, SEL_K0, SEL_K1, SEL_S, SEL_ONE
	} opnd_t;

	// register scale select for multiplier operand a
	typedef enum logic [2:0] {
		RA_WORD, RA_STEP, RA_ANOISE, RA_BNOISE, RA_MNOISE
	} rsel_t;

	typedef enum logic [1:0] {ALU_ADD, ALU_SUB, ALU_PASS} aluop_t;

	// destination registers
	typedef enum logic [3:0] {
		DST_NONE, DST_ANGLE, DST_BIAS, DST_P00, DST_P01, DST_P10, DST_P11,
		DST_RATE, DST_T, DST_U, DST_K0, DST_K1, DST_S, DST_KP00, DST_KP01
	} dst_t;

	// one microinstruction
	typedef struct packed {
		logic   mul_en;     // result = a*b >> shift, else add, sub or pass
		logic   reg_shift;  // shift by register fraction instead of word fraction
		rsel_t  rsel;
		opnd_t  a;
		opnd_t  b;
		aluop_t op;
		dst_t   dst;
		logic   div_start;
		logic   div_k1;     // divider numerator p10 / destination k1
	} cmd_t;

	typedef struct packed {
		logic mul_done;
		logic div_done;
	} stat_t;

	typedef enum logic [2:0] {
		ST_IDLE, ST_ISSUE, ST_MWAIT, ST_DWAIT, ST_OUT
	} state_t;

	localparam int unsigned PROG_LEN = 28;
	localparam int unsigned PC_WIDTH = 5;

	// Sequence of the filter step, one operation each.
	function automatic cmd_t prog(input logic [PC_WIDTH-1:0] pc);
		cmd_t c;
		c = '{mul_en:1'b0, reg_shift:1'b0, rsel:RA_WORD, a:SEL_ZERO, b:SEL_ZERO,
			op:ALU_PASS, dst:DST_NONE, div_start:1'b0, div_k1:1'b0};
		case (pc)
			5'd0: begin c.a = SEL_W; c.b = SEL_BIAS; c.op = ALU_SUB; c.dst = DST_RATE; end
			5'd1: begin c.mul_en = 1'b1; c.reg_shift = 1'b1; c.rsel = RA_STEP;
				c.b = SEL_RATE; c.dst = DST_T; end
			5'd2: begin c.a = SEL_ANGLE; c.b = SEL_T; c.op = ALU_ADD; c.dst = DST_ANGLE; end
			5'd3: begin c.mul_en = 1'b1; c.reg_shift = 1'b1; c.rsel = RA_STEP;
				c.b = SEL_P11; c.dst = DST_U; end
			5'd4: begin c.a = SEL_U; c.b = SEL_P01; c.op = ALU_SUB; c.dst = DST_T; end
			5'd5: begin c.a = SEL_T; c.b = SEL_P10; c.op = ALU_SUB; c.dst = DST_T; end
			5'd6: begin c.mul_en = 1'b1; c.reg_shift = 1'b1; c.rsel = RA_ANOISE;
				c.b = SEL_ONE; c.dst = DST_S; end
			5'd7: begin c.a = SEL_T; c.b = SEL_S; c.op = ALU_ADD; c.dst = DST_T; end
			5'd8: begin c.mul_en = 1'b1; c.reg_shift = 1'b1; c.rsel = RA_STEP;
				c.b = SEL_T; c.dst = DST_T; end
			5'd9: begin c.a = SEL_P00; c.b = SEL_T; c.op = ALU_ADD; c.dst = DST_P00; end
			5'd10: begin c.a = SEL_P01; c.b = SEL_U; c.op = ALU_SUB; c.dst = DST_P01; end
			5'd11: begin c.a = SEL_P10; c.b = SEL_U; c.op = ALU_SUB; c.dst = DST_P10; end
			5'd12: begin c.mul_en = 1'b1; c.reg_shift = 1'b1; c.rsel = RA_BNOISE;
				c.b = SEL_ONE; c.dst = DST_T; end
			5'd13: begin c.mul_en = 1'b1; c.reg_shift = 1'b1; c.rsel = RA_STEP;
				c.b = SEL_T; c.dst = DST_T; end
			5'd14: begin c.a = SEL_P11; c.b = SEL_T; c.op = ALU_ADD; c.dst = DST_P11; end
			5'd15: begin c.mul_en = 1'b1; c.reg_shift = 1'b1; c.rsel = RA_MNOISE;
				c.b = SEL_ONE; c.dst = DST_T; end
			5'd16: begin c.a = SEL_P00; c.b = SEL_T; c.op = ALU_ADD; c.dst = DST_S; end
			5'd17: begin c.div_start = 1'b1; end
			5'd18: begin c.div_start = 1'b1; c.div_k1 = 1'b1; end
			5'd19: begin c.a = SEL_Z; c.b = SEL_ANGLE; c.op = ALU_SUB; c.dst = DST_U; end
			5'd20: begin c.mul_en = 1'b1; c.a = SEL_K0; c.b = SEL_U; c.dst = DST_T; end
			5'd21: begin c.a = SEL_ANGLE; c.b = SEL_T; c.op = ALU_ADD; c.dst = DST_ANGLE; end
			5'd22: begin c.mul_en = 1'b1; c.a = SEL_K1; c.b = SEL_U; c.dst = DST_T; end
			5'd23: begin c.a = SEL_BIAS; c.b = SEL_T; c.op = ALU_ADD; c.dst = DST_BIAS; end
			// covariance update, p00 and p01 used before they are overwritten
			5'd24: begin c.mul_en = 1'b1; c.a = SEL_K1; c.b = SEL_P00; c.dst = DST_T; end
			5'd25: begin c.mul_en = 1'b1; c.a = SEL_K1; c.b = SEL_P01; c.dst = DST_U; end
			5'd26: begin c.mul_en = 1'b1; c.a = SEL_K0; c.b = SEL_P00; c.dst = DST_KP00; end
			5'd27: begin c.mul_en = 1'b1; c.a = SEL_K0; c.b = SEL_P01; c.dst = DST_KP01; end
			default: ;
		endcase
		return c;
	endfunction

endpackage

@@ src/kabf_ctrl.sv @@
// Sequencer of the filter: walks the operation list and runs the handshakes.
module kabf_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	output logic                  out_valid,
	input  logic                  out_stall,
	input  kabf_pkg::stat_t       stat,
	output kabf_pkg::cmd_t        cmd,
	output logic                  cmd_go,
	output logic                  load,
	output logic                  tail_go,
	output logic                  out_load
);
	kabf_pkg::state_t state_q, state_d;
	logic [kabf_pkg::PC_WIDTH-1:0] pc_q, pc_d;
	logic [2:0] tail_q, tail_d;
	logic ovalid_q, ovalid_d;

	// hold state, step counter, tail counter and output flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= kabf_pkg::ST_IDLE;
			pc_q     <= '0;
			tail_q   <= '0;
			ovalid_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			pc_q     <= pc_d;
			tail_q   <= tail_d;
			ovalid_q <= ovalid_d;
		end
	end

	assign cmd       = kabf_pkg::prog(pc_q);
	assign out_valid = ovalid_q;

	// sequence operations; multiplies wait for the multiplier, gains for the divider
	always_comb begin
		state_d  = state_q;
		pc_d     = pc_q;
		tail_d   = tail_q;
		ovalid_d = ovalid_q;
		in_stall = 1'b1;
		cmd_go   = 1'b0;
		load     = 1'b0;
		tail_go  = 1'b0;
		out_load = 1'b0;
		if (ovalid_q && !out_stall) ovalid_d = 1'b0;
		unique case (state_q)
			kabf_pkg::ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					load    = 1'b1;
					pc_d    = '0;
					tail_d  = '0;
					state_d = kabf_pkg::ST_ISSUE;
				end
			end
			kabf_pkg::ST_ISSUE: begin
				cmd_go = 1'b1;
				if (cmd.mul_en) state_d = kabf_pkg::ST_MWAIT;
				else if (cmd.div_start) state_d = kabf_pkg::ST_DWAIT;
				else if (pc_q == kabf_pkg::PC_WIDTH'(kabf_pkg::PROG_LEN - 1))
					state_d = kabf_pkg::ST_OUT;
				else pc_d = pc_q + 1'b1;
			end
			kabf_pkg::ST_MWAIT: begin
				if (stat.mul_done) begin
					if (pc_q == kabf_pkg::PC_WIDTH'(kabf_pkg::PROG_LEN - 1)) begin
						state_d = kabf_pkg::ST_OUT;
					end else begin
						pc_d    = pc_q + 1'b1;
						state_d = kabf_pkg::ST_ISSUE;
					end
				end
			end
			kabf_pkg::ST_DWAIT: begin
				if (stat.div_done) begin
					pc_d    = pc_q + 1'b1;
					state_d = kabf_pkg::ST_ISSUE;
				end
			end
			kabf_pkg::ST_OUT: begin
				// finish the covariance with the four k*p subtractions, then present
				if (tail_q != 3'd4) begin
					tail_go = 1'b1;
					tail_d  = tail_q + 3'd1;
				end else if (!ovalid_q || !out_stall) begin
					out_load = 1'b1;
					ovalid_d = 1'b1;
					state_d  = kabf_pkg::ST_IDLE;
				end
			end
			default: state_d = kabf_pkg::ST_IDLE;
		endcase
	end
endmodule

@@ src/kabf_mul.sv @@
// Signed multiplier, low and high half of b in turn, with floor shift and word saturation.
module kabf_mul #(
	parameter int unsigned WORD_WIDTH = kabf_pkg::WORD_WIDTH_DEF,
	parameter int unsigned FRAC_BITS  = kabf_pkg::FRAC_BITS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic                         reg_shift,
	input  logic signed [WORD_WIDTH-1:0] a,
	input  logic signed [WORD_WIDTH-1:0] b,
	output logic signed [WORD_WIDTH-1:0] p,
	output logic                         done
);
	localparam int unsigned HW = (WORD_WIDTH + 1) / 2;
	localparam int unsigned PW = 2 * WORD_WIDTH;
	localparam logic signed [PW-1:0] WMAX = PW'({1'b0, {(WORD_WIDTH-1){1'b1}}});
	localparam logic signed [PW-1:0] WMIN = -WMAX - PW'(1);

	logic signed [WORD_WIDTH-1:0] a_q;
	logic [HW-1:0] blo_q;
	logic signed [WORD_WIDTH-HW:0] bhi_q;
	logic sh_q;
	logic [1:0] ph_q;
	logic signed [PW-1:0] acc_q;
	logic signed [PW-1:0] part, sum, shd;

	// split b: unsigned low half first, signed high half second
	always_comb begin
		if (ph_q == 2'd1) part = PW'(a_q * $signed({1'b0, blo_q}));
		else              part = PW'(a_q * bhi_q) <<< HW;
		sum = acc_q + part;
		shd = sum >>> (sh_q ? kabf_pkg::REG_FRAC : FRAC_BITS);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_q <= '0;
			done <= 1'b0;
		end else begin
			done <= 1'b0;
			if (start) ph_q <= 2'd1;
			else if (ph_q == 2'd1) ph_q <= 2'd2;
			else if (ph_q == 2'd2) begin
				ph_q <= 2'd0;
				done <= 1'b1;
			end
		end
	end

	// accumulate partial products, saturate on the last
	always_ff @(posedge clk) begin
		if (start) begin
			a_q   <= a;
			blo_q <= b[HW-1:0];
			bhi_q <= $signed(b[WORD_WIDTH-1:HW-1]) >>> 1;
			sh_q  <= reg_shift;
			acc_q <= '0;
		end else if (ph_q == 2'd1) begin
			acc_q <= sum;
		end else if (ph_q == 2'd2) begin
			if (shd > WMAX)      p <= WMAX[WORD_WIDTH-1:0];
			else if (shd < WMIN) p <= WMIN[WORD_WIDTH-1:0];
			else                 p <= shd[WORD_WIDTH-1:0];
		end
	end
endmodule

@@ src/kabf_div.sv @@
// Restoring divider for the gains, one quotient bit a cycle.
module kabf_div #(
	parameter int unsigned WORD_WIDTH = kabf_pkg::WORD_WIDTH_DEF,
	parameter int unsigned FRAC_BITS  = kabf_pkg::FRAC_BITS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic signed [WORD_WIDTH-1:0] num,
	input  logic signed [WORD_WIDTH-1:0] den,
	output logic signed [WORD_WIDTH-1:0] quo,
	output logic                         done
);
	localparam int unsigned NW = WORD_WIDTH + FRAC_BITS;
	localparam int unsigned CW = $clog2(NW + 1);
	localparam logic [NW-1:0] WMAX = NW'({1'b0, {(WORD_WIDTH-1){1'b1}}});

	logic [NW-1:0] n_q, q_q;
	logic [WORD_WIDTH:0] r_q, d_q, rs;
	logic [CW-1:0] cnt_q;
	logic neg_q, busy_q, zero_q, fin_q;

	assign rs = {r_q[WORD_WIDTH-1:0], n_q[NW-1]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			fin_q  <= 1'b0;
			done   <= 1'b0;
		end else begin
			done  <= fin_q;
			fin_q <= 1'b0;
			if (start) busy_q <= 1'b1;
			else if (busy_q && (zero_q || cnt_q == CW'(NW - 1))) begin
				busy_q <= 1'b0;
				fin_q  <= 1'b1;
			end
		end
	end

	// shift in one dividend bit, subtract if it fits
	always_ff @(posedge clk) begin
		if (start) begin
			n_q    <= NW'($unsigned(num[WORD_WIDTH-1] ? -num : num)) << FRAC_BITS;
			d_q    <= (WORD_WIDTH+1)'($unsigned(den[WORD_WIDTH-1] ? -den : den));
			zero_q <= (den == '0);
			neg_q  <= num[WORD_WIDTH-1] ^ den[WORD_WIDTH-1];
			r_q    <= '0;
			q_q    <= '0;
			cnt_q  <= '0;
		end else if (busy_q) begin
			n_q   <= n_q << 1;
			cnt_q <= cnt_q + 1'b1;
			if (rs >= d_q) begin
				r_q <= rs - d_q;
				q_q <= {q_q[NW-2:0], 1'b1};
			end else begin
				r_q <= rs;
				q_q <= {q_q[NW-2:0], 1'b0};
			end
		end else if (fin_q) begin
			if (zero_q)          quo <= '0;
			else if (q_q > WMAX) quo <= neg_q ? ~WMAX[WORD_WIDTH-1:0] : WMAX[WORD_WIDTH-1:0];
			else                 quo <= neg_q ? -q_q[WORD_WIDTH-1:0] : q_q[WORD_WIDTH-1:0];
		end
	end
endmodule

@@ src/kabf_dp.sv @@
// Datapath: filter state, scratch registers, saturating adder, multiplier and divider.
module kabf_dp #(
	parameter int unsigned WORD_WIDTH = kabf_pkg::WORD_WIDTH_DEF,
	parameter int unsigned FRAC_BITS  = kabf_pkg::FRAC_BITS_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  kabf_pkg::cmd_t                        cmd,
	input  logic                                  cmd_go,
	input  logic                                  load,
	input  logic                                  tail_go,
	input  logic                                  out_load,
	output kabf_pkg::stat_t                       stat,
	input  logic                                  cfg_we,
	input  logic [kabf_pkg::CFG_IDX_WIDTH-1:0]    cfg_idx,
	input  logic [kabf_pkg::REG_WIDTH-1:0]        cfg_data,
	input  logic signed [kabf_pkg::FIELD_WIDTH-1:0] z_in,
	input  logic signed [kabf_pkg::FIELD_WIDTH-1:0] w_in,
	output logic signed [kabf_pkg::FIELD_WIDTH-1:0] angle_out,
	output logic signed [kabf_pkg::FIELD_WIDTH-1:0] bias_out,
	output logic signed [kabf_pkg::FIELD_WIDTH-1:0] rate_out
);
	localparam int unsigned W = WORD_WIDTH;
	localparam int unsigned FW = kabf_pkg::FIELD_WIDTH;
	localparam int unsigned XW = (W > FW) ? W : FW;
	localparam logic signed [W:0] WMAX = (W+1)'({1'b0, {(W-1){1'b1}}});
	localparam logic signed [W:0] WMIN = -WMAX - (W+1)'(1);
	localparam logic signed [XW:0] FMAX = (XW+1)'({1'b0, {(FW-1){1'b1}}});
	localparam logic signed [XW:0] FMIN = -FMAX - (XW+1)'(1);
	localparam logic signed [XW:0] WXMAX = (XW+1)'({1'b0, {(W-1){1'b1}}});
	localparam logic signed [XW:0] WXMIN = -WXMAX - (XW+1)'(1);

	logic [kabf_pkg::REG_WIDTH-1:0] anoise_q, bnoise_q, mnoise_q, step_q;
	logic signed [W-1:0] angle_q, bias_q, p00_q, p01_q, p10_q, p11_q;
	logic signed [W-1:0] z_q, w_q, rate_q, t_q, u_q, k0_q, k1_q, s_q;
	logic signed [W-1:0] kp00_q, kp01_q;
	logic signed [W-1:0] opa, opb, mul_a, mul_p, div_q, res;
	logic signed [W:0] sum;
	kabf_pkg::dst_t dst_q;
	logic div_k1_q;
	logic [1:0] tail_q;
	logic signed [W-1:0] ta, tb;

	function automatic logic signed [W-1:0] sat_w(input logic signed [W:0] v);
		if (v > WMAX) return WMAX[W-1:0];
		if (v < WMIN) return WMIN[W-1:0];
		return v[W-1:0];
	endfunction

	function automatic logic signed [XW:0] ext_f(input logic signed [FW-1:0] v);
		return (XW+1)'(v);
	endfunction

	function automatic logic signed [W-1:0] in_w(input logic signed [FW-1:0] v);
		logic signed [XW:0] x;
		x = ext_f(v);
		if (x > WXMAX) x = WXMAX;
		if (x < WXMIN) x = WXMIN;
		return x[W-1:0];
	endfunction

	function automatic logic signed [FW-1:0] out_f(input logic signed [W-1:0] v);
		logic signed [XW:0] x;
		x = (XW+1)'(v);
		if (x > FMAX) x = FMAX;
		if (x < FMIN) x = FMIN;
		return x[FW-1:0];
	endfunction

	function automatic logic signed [W-1:0] pick(input kabf_pkg::opnd_t s,
		input logic signed [W-1:0] an, bi, q00, q01, q10, q11, zz, ww, rt, tt, uu,
		kk0, kk1, ss);
		logic signed [W-1:0] r;
		r = '0;
		case (s)
			kabf_pkg::SEL_ANGLE: r = an;
			kabf_pkg::SEL_BIAS:  r = bi;
			kabf_pkg::SEL_P00:   r = q00;
			kabf_pkg::SEL_P01:   r = q01;
			kabf_pkg::SEL_P10:   r = q10;
			kabf_pkg::SEL_P11:   r = q11;
			kabf_pkg::SEL_Z:     r = zz;
			kabf_pkg::SEL_W:     r = ww;
			kabf_pkg::SEL_RATE:  r = rt;
			kabf_pkg::SEL_T:     r = tt;
			kabf_pkg::SEL_U:     r = uu;
			kabf_pkg::SEL_K0:    r = kk0;
			kabf_pkg::SEL_K1:    r = kk1;
			kabf_pkg::SEL_S:     r = ss;
			kabf_pkg::SEL_ONE:   r = W'(1) << FRAC_BITS;
			default:             r = '0;
		endcase
		return r;
	endfunction

	assign opa = pick(cmd.a, angle_q, bias_q, p00_q, p01_q, p10_q, p11_q, z_q, w_q,
		rate_q, t_q, u_q, k0_q, k1_q, s_q);
	assign opb = pick(cmd.b, angle_q, bias_q, p00_q, p01_q, p10_q, p11_q, z_q, w_q,
		rate_q, t_q, u_q, k0_q, k1_q, s_q);

	// register operands zero-extend into the word
	always_comb begin
		case (cmd.rsel)
			kabf_pkg::RA_STEP:   mul_a = W'(step_q);
			kabf_pkg::RA_ANOISE: mul_a = W'(anoise_q);
			kabf_pkg::RA_BNOISE: mul_a = W'(bnoise_q);
			kabf_pkg::RA_MNOISE: mul_a = W'(mnoise_q);
			default:             mul_a = opa;
		endcase
		case (cmd.op)
			kabf_pkg::ALU_ADD: sum = (W+1)'(opa) + (W+1)'(opb);
			kabf_pkg::ALU_SUB: sum = (W+1)'(opa) - (W+1)'(opb);
			default:           sum = (W+1)'(opa);
		endcase
		res = sat_w(sum);
	end

	kabf_mul #(.WORD_WIDTH(W), .FRAC_BITS(FRAC_BITS)) u_mul (
		.clk(clk), .arst_n(arst_n), .start(cmd_go && cmd.mul_en),
		.reg_shift(cmd.reg_shift), .a(mul_a), .b(opb), .p(mul_p), .done(stat.mul_done)
	);

	kabf_div #(.WORD_WIDTH(W), .FRAC_BITS(FRAC_BITS)) u_div (
		.clk(clk), .arst_n(arst_n), .start(cmd_go && cmd.div_start),
		.num(cmd.div_k1 ? p10_q : p00_q), .den(s_q), .quo(div_q), .done(stat.div_done)
	);

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			anoise_q <= kabf_pkg::ANGLE_NOISE_RST;
			bnoise_q <= kabf_pkg::BIAS_NOISE_RST;
			mnoise_q <= kabf_pkg::MEASURE_NOISE_RST;
			step_q   <= kabf_pkg::STEP_TIME_RST;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				kabf_pkg::REG_ANGLE_NOISE:   anoise_q <= cfg_data;
				kabf_pkg::REG_BIAS_NOISE:    bnoise_q <= cfg_data;
				kabf_pkg::REG_MEASURE_NOISE: mnoise_q <= cfg_data;
				kabf_pkg::REG_STEP_TIME:     step_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	// tail 0: p10 -= t (k1*p00), tail 1: p11 -= u (k1*p01)
	// tail 2/3: p00 and p01 subtract the k0 products left by the last two operations
	assign ta = (tail_q == 2'd0) ? p10_q : p11_q;
	assign tb = (tail_q == 2'd0) ? t_q : u_q;

	// filter state and control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			angle_q  <= '0;
			bias_q   <= '0;
			p00_q    <= '0;
			p01_q    <= '0;
			p10_q    <= '0;
			p11_q    <= '0;
			dst_q    <= kabf_pkg::DST_NONE;
			div_k1_q <= 1'b0;
			tail_q   <= '0;
		end else begin
			if (load) tail_q <= '0;
			if (cmd_go) begin
				dst_q    <= cmd.dst;
				div_k1_q <= cmd.div_k1;
			end
			if (tail_go) begin
				tail_q <= tail_q + 1'b1;
				case (tail_q)
					2'd0: p10_q <= sat_w((W+1)'(ta) - (W+1)'(tb));
					2'd1: p11_q <= sat_w((W+1)'(ta) - (W+1)'(tb));
					2'd2: p00_q <= sat_w((W+1)'(p00_q) - (W+1)'(kp00_q));
					default: p01_q <= sat_w((W+1)'(p01_q) - (W+1)'(kp01_q));
				endcase
			end
			if ((cmd_go && !cmd.mul_en && !cmd.div_start) || stat.mul_done) begin
				case (stat.mul_done ? dst_q : cmd.dst)
					kabf_pkg::DST_ANGLE: angle_q <= stat.mul_done ? mul_p : res;
					kabf_pkg::DST_BIAS:  bias_q  <= stat.mul_done ? mul_p : res;
					kabf_pkg::DST_P00:   p00_q   <= stat.mul_done ? mul_p : res;
					kabf_pkg::DST_P01:   p01_q   <= stat.mul_done ? mul_p : res;
					kabf_pkg::DST_P10:   p10_q   <= stat.mul_done ? mul_p : res;
					kabf_pkg::DST_P11:   p11_q   <= stat.mul_done ? mul_p : res;
					default: ;
				endcase
			end
		end
	end

	// scratch registers hold payload only
	always_ff @(posedge clk) begin
		if (load) begin
			z_q <= in_w(z_in);
			w_q <= in_w(w_in);
		end
		if (stat.div_done) begin
			if (div_k1_q) k1_q <= div_q;
			else          k0_q <= div_q;
		end
		if ((cmd_go && !cmd.mul_en && !cmd.div_start) || stat.mul_done) begin
			case (stat.mul_done ? dst_q : cmd.dst)
				kabf_pkg::DST_RATE: rate_q <= stat.mul_done ? mul_p : res;
				kabf_pkg::DST_T:    t_q    <= stat.mul_done ? mul_p : res;
				kabf_pkg::DST_U:    u_q    <= stat.mul_done ? mul_p : res;
				kabf_pkg::DST_S:    s_q    <= stat.mul_done ? mul_p : res;
				kabf_pkg::DST_KP00: kp00_q <= stat.mul_done ? mul_p : res;
				kabf_pkg::DST_KP01: kp01_q <= stat.mul_done ? mul_p : res;
				default: ;
			endcase
		end
		if (out_load) begin
			angle_out <= out_f(angle_q);
			bias_out  <= out_f(bias_q);
			rate_out  <= out_f(rate_q);
		end
	end
endmodule

@@ src/kalman_angle_bias_filter.sv @@
// Two-state angle and gyro bias filter, one axis: top level.
// Takes one word of measured angle and rate and returns one word of filtered angle, bias and
// unbiased rate. A sequencer runs 28 operations through one shared saturating adder, a
// multiplier and a bit-serial divider that stops early when the innovation variance is
// zero, then four covariance subtractions. The block takes one item at a time, and a
// finished result is held back while the previous one is still stalled at the output.
module kalman_angle_bias_filter #(
	parameter int unsigned WORD_WIDTH = kabf_pkg::WORD_WIDTH_DEF,
	parameter int unsigned FRAC_BITS  = kabf_pkg::FRAC_BITS_DEF
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   in_valid,
	output logic                                   in_stall,
	input  logic signed [kabf_pkg::FIELD_WIDTH-1:0] measured_angle,
	input  logic signed [kabf_pkg::FIELD_WIDTH-1:0] measured_rate,
	output logic                                   out_valid,
	input  logic                                   out_stall,
	output logic signed [kabf_pkg::FIELD_WIDTH-1:0] filtered_angle,
	output logic signed [kabf_pkg::FIELD_WIDTH-1:0] rate_bias,
	output logic signed [kabf_pkg::FIELD_WIDTH-1:0] unbiased_rate,
	input  logic                                   cfg_we,
	input  logic [kabf_pkg::CFG_IDX_WIDTH-1:0]     cfg_idx,
	input  logic [kabf_pkg::REG_WIDTH-1:0]         cfg_data
);
	kabf_pkg::cmd_t  cmd;
	kabf_pkg::stat_t stat;
	logic cmd_go, load, tail_go, out_load;

	kabf_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
		.out_valid(out_valid), .out_stall(out_stall), .stat(stat), .cmd(cmd),
		.cmd_go(cmd_go), .load(load), .tail_go(tail_go), .out_load(out_load)
	);

	kabf_dp #(.WORD_WIDTH(WORD_WIDTH), .FRAC_BITS(FRAC_BITS)) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .cmd_go(cmd_go), .load(load),
		.tail_go(tail_go), .out_load(out_load), .stat(stat), .cfg_we(cfg_we),
		.cfg_idx(cfg_idx), .cfg_data(cfg_data), .z_in(measured_angle),
		.w_in(measured_rate), .angle_out(filtered_angle), .bias_out(rate_bias),
		.rate_out(unbiased_rate)
	);
endmodule
